// ===== rtl/afrv_pkg.sv =====
`default_nettype none

package afrv_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned FRAME_FIELDS = 6;
    localparam int unsigned CAPTURE_DEPTH = FRAME_FIELDS - 1;
    localparam int unsigned COUNT_W = 3;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_BYTE  = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_IOERR = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_ACK      = 3'd0,
        ST_NACK     = 3'd1,
        ST_TIMEOUT  = 3'd2,
        ST_BAD_CMD  = 3'd3,
        ST_BAD_LEN  = 3'd4,
        ST_BAD_SEQ  = 3'd5,
        ST_BAD_SUM  = 3'd6,
        ST_IO_ERROR = 3'd7
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_COMMAND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NACK_COMMAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_HIGH   = 3'd5;

    localparam logic [7:0] RST_HEADER_FIRST  = 8'd170;
    localparam logic [7:0] RST_HEADER_SECOND = 8'd85;
    localparam logic [7:0] RST_ACK_COMMAND   = 8'd2;
    localparam logic [7:0] RST_NACK_COMMAND  = 8'd3;
    localparam logic [7:0] RST_LENGTH_LOW    = 8'd2;
    localparam logic [7:0] RST_LENGTH_HIGH   = 8'd0;

    typedef struct packed {
        logic [7:0] checksum_seen;
        logic [7:0] checksum_computed;
        logic [7:0] error_byte;
        logic [7:0] sequence_byte;
        logic [7:0] command_byte;
    } t_result_data;

endpackage

`default_nettype wire

// ===== rtl/ack_frame_receiver_validator.sv =====
// Acknowledge frame receiver and checker.
// The input stream carries one event per transfer: tuser selects start, received byte,
// millisecond tick or receive I/O error; tdata carries the byte, the expected sequence
// number and the timeout. A start with a non-zero timeout arms the block; it then hunts
// for the two header bytes, captures the six frame bytes and checks command, length,
// sequence and XOR checksum. A start with a zero timeout yields a timeout result.
// At most one result is produced per input transfer: status on tuser, the captured bytes
// and both checksums on tdata (all zero for timeout and I/O error results). A result
// passes through one input register and one result register, with the frame state
// updated in the single step between them. Throughput is one input transfer per cycle;
// the input side keeps accepting while a result waits in the output register, and stalls
// only when both registers are full and the receiver holds tready low.
// The configuration channel is always ready and writes one 8-bit register per transfer;
// indices beyond the register list are ignored. The user must make writes only while the
// block is idle; the block does not enforce this. After reset it is idle with the default
// header, command and length values, and bytes, ticks and errors are ignored until a start.
`default_nettype none

module ack_frame_receiver_validator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // rx_byte [7:0], expected_sequence [15:8], timeout_limit [31:16]
    input  wire logic [31:0]                   s_axis_tdata,
    // func [1:0]
    input  wire logic [1:0]                    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // command_byte [7:0], sequence_byte [15:8], error_byte [23:16],
    // checksum_computed [31:24], checksum_seen [39:32]
    output logic [39:0]                        m_axis_tdata,
    // status [2:0]
    output logic [2:0]                         m_axis_tuser,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [afrv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                    i_cfg_data
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HUNT    = 2'd1,
        PH_FIRST   = 2'd2,
        PH_CAPTURE = 2'd3
    } t_phase;

    logic [7:0] r_header_first, r_header_second, r_ack_command, r_nack_command;
    logic [7:0] r_length_low, r_length_high;

    logic                r_in_valid;
    afrv_pkg::t_func     r_func;
    logic [31:0]         r_in_data;

    t_phase                          r_phase, n_phase;
    logic [afrv_pkg::COUNT_W-1:0]    r_count, n_count;
    logic [7:0]                      r_cap [afrv_pkg::CAPTURE_DEPTH];
    logic [7:0]                      r_seq_wanted, n_seq_wanted;
    logic [15:0]                     r_ms_left, n_ms_left;
    logic                            n_cap_we;

    logic                   r_out_valid;
    afrv_pkg::t_status      r_out_status, n_out_status;
    afrv_pkg::t_result_data r_out_data, n_out_data;
    logic                   n_emit;

    logic       w_advance;
    logic [7:0] w_byte;
    logic [7:0] w_sum;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    assign w_byte = r_in_data[7:0];
    assign w_sum  = r_cap[0] ^ r_length_low ^ r_length_high ^ r_cap[3] ^ r_cap[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= afrv_pkg::RST_HEADER_FIRST;
            r_header_second <= afrv_pkg::RST_HEADER_SECOND;
            r_ack_command   <= afrv_pkg::RST_ACK_COMMAND;
            r_nack_command  <= afrv_pkg::RST_NACK_COMMAND;
            r_length_low    <= afrv_pkg::RST_LENGTH_LOW;
            r_length_high   <= afrv_pkg::RST_LENGTH_HIGH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                afrv_pkg::CFG_HEADER_FIRST:  r_header_first  <= i_cfg_data;
                afrv_pkg::CFG_HEADER_SECOND: r_header_second <= i_cfg_data;
                afrv_pkg::CFG_ACK_COMMAND:   r_ack_command   <= i_cfg_data;
                afrv_pkg::CFG_NACK_COMMAND:  r_nack_command  <= i_cfg_data;
                afrv_pkg::CFG_LENGTH_LOW:    r_length_low    <= i_cfg_data;
                afrv_pkg::CFG_LENGTH_HIGH:   r_length_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_func    <= afrv_pkg::t_func'(s_axis_tuser);
            r_in_data <= s_axis_tdata;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_seq_wanted = r_seq_wanted;
        n_ms_left    = r_ms_left;
        n_cap_we     = 1'b0;
        n_emit       = 1'b0;
        n_out_status = afrv_pkg::ST_TIMEOUT;
        n_out_data   = '0;

        if (r_func == afrv_pkg::FUNC_START) begin
            n_seq_wanted = r_in_data[15:8];
            n_ms_left    = r_in_data[31:16];
            n_count      = '0;
            if (r_in_data[31:16] == 16'd0) begin
                n_emit  = 1'b1;
                n_phase = PH_IDLE;
            end else begin
                n_phase = PH_HUNT;
            end
        end else if (r_phase != PH_IDLE) begin
            unique case (r_func)
                afrv_pkg::FUNC_TICK: begin
                    n_ms_left = r_ms_left - 16'd1;
                    if (r_ms_left == 16'd1) begin
                        n_emit  = 1'b1;
                        n_phase = PH_IDLE;
                        n_count = '0;
                    end
                end
                afrv_pkg::FUNC_IOERR: begin
                    n_emit       = 1'b1;
                    n_out_status = afrv_pkg::ST_IO_ERROR;
                    n_phase      = PH_IDLE;
                    n_count      = '0;
                end
                default: begin
                    unique case (r_phase)
                        PH_HUNT: begin
                            if (w_byte == r_header_first) begin
                                n_phase = PH_FIRST;
                            end
                        end
                        PH_FIRST: begin
                            if (w_byte == r_header_second) begin
                                n_phase = PH_CAPTURE;
                                n_count = '0;
                            end else if (w_byte == r_header_first) begin
                                n_phase = PH_FIRST;
                            end else begin
                                n_phase = PH_HUNT;
                            end
                        end
                        default: begin
                            if (r_count < afrv_pkg::COUNT_W'(afrv_pkg::CAPTURE_DEPTH)) begin
                                n_cap_we = 1'b1;
                                n_count  = r_count + 1'b1;
                            end else begin
                                n_emit  = 1'b1;
                                n_phase = PH_IDLE;
                                n_count = '0;
                                n_out_data.command_byte      = r_cap[0];
                                n_out_data.sequence_byte     = r_cap[3];
                                n_out_data.error_byte        = r_cap[4];
                                n_out_data.checksum_computed = w_sum;
                                n_out_data.checksum_seen     = w_byte;
                                if (r_cap[0] != r_ack_command && r_cap[0] != r_nack_command) begin
                                    n_out_status = afrv_pkg::ST_BAD_CMD;
                                end else if (r_cap[1] != r_length_low
                                             || r_cap[2] != r_length_high) begin
                                    n_out_status = afrv_pkg::ST_BAD_LEN;
                                end else if (r_cap[3] != r_seq_wanted) begin
                                    n_out_status = afrv_pkg::ST_BAD_SEQ;
                                end else if (w_byte != w_sum) begin
                                    n_out_status = afrv_pkg::ST_BAD_SUM;
                                end else if (r_cap[0] == r_ack_command) begin
                                    n_out_status = afrv_pkg::ST_ACK;
                                end else begin
                                    n_out_status = afrv_pkg::ST_NACK;
                                end
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_count      <= '0;
            r_seq_wanted <= '0;
            r_ms_left    <= '0;
            r_out_valid  <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid && n_emit;
            if (r_in_valid) begin
                r_phase      <= n_phase;
                r_count      <= n_count;
                r_seq_wanted <= n_seq_wanted;
                r_ms_left    <= n_ms_left;
            end
        end
        if (w_advance && r_in_valid) begin
            if (n_cap_we) begin
                r_cap[r_count] <= w_byte;
            end
            if (n_emit) begin
                r_out_status <= n_out_status;
                r_out_data   <= n_out_data;
            end
        end
    end

`ifndef SYNTH
    a_empty_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == afrv_pkg::ST_TIMEOUT
                          || m_axis_tuser == afrv_pkg::ST_IO_ERROR)
        |-> m_axis_tdata == '0)
        else $error("timeout or I/O error result carries non-zero bytes");

    a_result_ends_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in_valid && n_emit |=> r_phase == PH_IDLE && r_count == '0)
        else $error("wait still armed after a result");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= afrv_pkg::COUNT_W'(afrv_pkg::CAPTURE_DEPTH))
        else $error("capture count beyond frame length");

    a_armed_has_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> r_ms_left != 16'd0)
        else $error("armed wait with no time left");
`endif

endmodule

`default_nettype wire
